### hw/rtl/wpla_pkg.sv
// ----------------------------------------------------------------------------
// Weighted packet loss average: shared package
// Field widths, fixed-point constants and default sizes for the block.
// ----------------------------------------------------------------------------
`default_nettype none

package wpla_pkg;

  // Width of the lost and expected counts of one feedback report.
  localparam int unsigned COUNT_W = 16;

  // Fixed-point format of a loss ratio: FRACTION_BITS fraction bits and one
  // integer bit, so that a ratio of exactly 1.0 can be held.
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned LOSS_W        = FRACTION_BITS + 1;

  // Width of the history fill field on the result channel.
  localparam int unsigned FILL_W = 5;

  // Default number of reports kept in the history.
  localparam int unsigned HISTORY_DEPTH = 24;

  // A loss ratio of 1.0.
  localparam logic [LOSS_W-1:0] LOSS_ONE = LOSS_W'(1) << FRACTION_BITS;

endpackage : wpla_pkg

`default_nettype wire

### hw/rtl/wpla_in_if.sv
// ----------------------------------------------------------------------------
// Weighted packet loss average: report channel
// Valid/ready channel that carries one feedback report per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpla_in_if;

  logic                         valid;
  logic                         ready;
  logic [wpla_pkg::COUNT_W-1:0] lost_count;
  logic [wpla_pkg::COUNT_W-1:0] expected_count;

  modport source (output valid, output lost_count, output expected_count, input ready);
  modport sink   (input valid, input lost_count, input expected_count, output ready);

endinterface : wpla_in_if

`default_nettype wire

### hw/rtl/wpla_out_if.sv
// ----------------------------------------------------------------------------
// Weighted packet loss average: result channel
// Valid/ready channel that carries one loss result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface wpla_out_if;

  logic                        valid;
  logic                        ready;
  logic [wpla_pkg::LOSS_W-1:0] current_loss;
  logic [wpla_pkg::LOSS_W-1:0] weighted_loss;
  logic [wpla_pkg::FILL_W-1:0] history_fill;
  logic                        empty_report;

  modport source (
    output valid, output current_loss, output weighted_loss,
    output history_fill, output empty_report, input ready
  );
  modport sink (
    input valid, input current_loss, input weighted_loss,
    input history_fill, input empty_report, output ready
  );

endinterface : wpla_out_if

`default_nettype wire

### hw/rtl/wpla_div.sv
// ----------------------------------------------------------------------------
// Weighted packet loss average: bit-serial divider
// Restoring divider that produces one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module wpla_div #(
  parameter int unsigned DEN_W = 16,
  parameter int unsigned Q_W   = 17
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DEN_W-1:0] rem_init_i,
  input  wire logic [Q_W-1:0]   low_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [Q_W-1:0]        quot_o
);

  localparam int unsigned CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem_q, rem_d;
  logic [Q_W-1:0]   shift_q, shift_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             q_bit;

  // One restoring step: the remainder stays below the divisor, so the trial
  // value is below twice the divisor and one subtract is enough.
  always_comb begin
    trial   = {rem_q, shift_q[Q_W-1]};
    q_bit   = (trial >= {1'b0, den_q});
    rem_d   = q_bit ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    shift_d = {shift_q[Q_W-2:0], q_bit};
    cnt_d   = cnt_q - CNT_W'(1);
    done_d  = (cnt_q == CNT_W'(1));
  end

  // Control: the step counter and the completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(Q_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: the dividend bits shift out at the top while quotient bits
  // shift in at the bottom of the same register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q   <= rem_init_i;
      shift_q <= low_i;
      den_q   <= den_i;
    end else if (cnt_q != '0) begin
      rem_q   <= rem_d;
      shift_q <= shift_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = shift_q;

endmodule : wpla_div

`default_nettype wire

### hw/rtl/wpla_hist.sv
// ----------------------------------------------------------------------------
// Weighted packet loss average: history and weighted sum
// Ring buffer of loss ratios and a serial walk that forms the weighted sum.
// ----------------------------------------------------------------------------
`default_nettype none

module wpla_hist #(
  parameter int unsigned HISTORY_DEPTH = wpla_pkg::HISTORY_DEPTH,
  parameter int unsigned FILL_CNT_W    = $clog2(HISTORY_DEPTH + 1),
  parameter int unsigned WT_W          = $clog2(HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2 + 1),
  parameter int unsigned TOT_W         = wpla_pkg::LOSS_W + WT_W
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [wpla_pkg::LOSS_W-1:0] ratio_i,
  output logic                             done_o,
  output logic [TOT_W-1:0]                 total_o,
  output logic [WT_W-1:0]                  weights_o,
  output logic [FILL_CNT_W-1:0]            fill_o
);

  localparam int unsigned ADDR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned SUM_W  = wpla_pkg::LOSS_W + FILL_CNT_W;

  localparam logic [ADDR_W:0]       DEPTH_X = (ADDR_W + 1)'(HISTORY_DEPTH);
  localparam logic [ADDR_W-1:0]     LAST    = ADDR_W'(HISTORY_DEPTH - 1);
  localparam logic [FILL_CNT_W-1:0] FULL    = FILL_CNT_W'(HISTORY_DEPTH);

  logic [wpla_pkg::LOSS_W-1:0] mem_q [HISTORY_DEPTH];
  logic [wpla_pkg::LOSS_W-1:0] rd_q;

  logic [FILL_CNT_W-1:0] fill_q;
  logic [ADDR_W-1:0]     oldest_q;
  logic [ADDR_W-1:0]     oldest_d;
  logic                  full;
  logic [ADDR_W:0]       slot_sum;
  logic [ADDR_W-1:0]     slot;

  logic                  walk_q;
  logic [FILL_CNT_W-1:0] remain_q;
  logic [ADDR_W-1:0]     addr_q;
  logic                  rd_vld_q;
  logic                  done_q;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [TOT_W-1:0]      tot_q, tot_d;
  logic [WT_W-1:0]       wt_q, wt_d;
  logic [FILL_CNT_W-1:0] cnt_q;

  // Write slot: after the newest entry while filling, over the oldest once full.
  always_comb begin
    full     = (fill_q == FULL);
    slot_sum = {1'b0, oldest_q} + (ADDR_W + 1)'(fill_q);
    if (full) begin
      slot = oldest_q;
    end else if (slot_sum >= DEPTH_X) begin
      slot = ADDR_W'(slot_sum - DEPTH_X);
    end else begin
      slot = slot_sum[ADDR_W-1:0];
    end
    oldest_d = (slot == LAST) ? '0 : slot + ADDR_W'(1);
  end

  // Accumulate from newest to oldest: the running sum is added into the total
  // once per step, so the newest entry is counted n times and the oldest once.
  always_comb begin
    sum_d = sum_q + SUM_W'(rd_q);
    tot_d = tot_q + TOT_W'(sum_d);
    wt_d  = wt_q + WT_W'(cnt_q) + WT_W'(1);
  end

  // History memory: one write port for the push, one registered read port.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[slot] <= ratio_i;
    end
    rd_q <= mem_q[addr_q];
  end

  // Fill count and oldest pointer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      oldest_q <= '0;
    end else if (push_i) begin
      if (full) begin
        oldest_q <= oldest_d;
      end else begin
        fill_q <= fill_q + FILL_CNT_W'(1);
      end
    end
  end

  // Walk control: one read issued per cycle, consumed in the cycle after.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q   <= 1'b0;
      remain_q <= '0;
      addr_q   <= '0;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else if (push_i) begin
      walk_q   <= 1'b1;
      remain_q <= full ? fill_q : fill_q + FILL_CNT_W'(1);
      addr_q   <= slot;
      rd_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (walk_q) begin
        if (remain_q != '0) begin
          rd_vld_q <= 1'b1;
          remain_q <= remain_q - FILL_CNT_W'(1);
          addr_q   <= (addr_q == '0) ? LAST : addr_q - ADDR_W'(1);
        end else begin
          rd_vld_q <= 1'b0;
          if (!rd_vld_q) begin
            walk_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  // Accumulators.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      sum_q <= '0;
      tot_q <= '0;
      wt_q  <= '0;
      cnt_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_d;
      tot_q <= tot_d;
      wt_q  <= wt_d;
      cnt_q <= cnt_q + FILL_CNT_W'(1);
    end
  end

  assign done_o    = done_q;
  assign total_o   = tot_q;
  assign weights_o = wt_q;
  assign fill_o    = fill_q;

endmodule : wpla_hist

`default_nettype wire

### hw/rtl/weighted_packet_loss_average.sv
// ----------------------------------------------------------------------------
// Weighted packet loss average: top level
// Loss ratio per feedback report and its linearly weighted history average.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one feedback report per transaction (lost and expected
//   counts). out_o carries one result per report: the report's loss ratio,
//   the weighted average over the history, the history fill and a flag for
//   a report with an expected count of zero.
//   The block works on one report at a time. A report passes through the
//   bit-serial divider (one quotient bit per cycle, used twice) and the
//   history walk (one memory read per cycle for each report held) before
//   its result is valid. Reports with lost >= expected or expected == 0
//   skip the first division. Once the result is loaded into the output
//   register the block is ready for the next report.
//   A new report is taken while the previous result still waits on out_o;
//   if the receiver stalls, the block holds its next result until the output
//   register is free. Reset empties the history and drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_packet_loss_average #(
  parameter int unsigned HISTORY_DEPTH = wpla_pkg::HISTORY_DEPTH
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  wpla_in_if.sink     in_i,
  wpla_out_if.source  out_o
);

  localparam int unsigned LOSS_W     = wpla_pkg::LOSS_W;
  localparam int unsigned COUNT_W    = wpla_pkg::COUNT_W;
  localparam int unsigned FRAC_W     = wpla_pkg::FRACTION_BITS;
  localparam int unsigned FILL_W     = wpla_pkg::FILL_W;
  localparam int unsigned FILL_CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned WT_W       = $clog2(HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2 + 1);
  localparam int unsigned TOT_W      = LOSS_W + WT_W;
  localparam int unsigned DEN_W      = (COUNT_W > WT_W) ? COUNT_W : WT_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RATIO = 3'd1;
  localparam logic [2:0] S_PUSH  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_AVG   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic              in_acc;
  logic              no_expected;
  logic              saturate;

  logic [LOSS_W-1:0] ratio_q, ratio_d;
  logic              empty_q, empty_d;
  logic [LOSS_W-1:0] avg_q, avg_d;

  logic              out_vld_q;
  logic [LOSS_W-1:0] out_cur_q;
  logic [LOSS_W-1:0] out_avg_q;
  logic [FILL_W-1:0] out_fill_q;
  logic              out_empty_q;
  logic              out_load;

  logic              div_start;
  logic [DEN_W-1:0]  div_rem_init;
  logic [LOSS_W-1:0] div_low;
  logic [DEN_W-1:0]  div_den;
  logic              div_done;
  logic [LOSS_W-1:0] div_quot;

  logic                  hist_push;
  logic                  hist_done;
  logic [TOT_W-1:0]      hist_total;
  logic [WT_W-1:0]       hist_weights;
  logic [FILL_CNT_W-1:0] hist_fill;
  logic [FILL_CNT_W+FILL_W-1:0] fill_ext;

  assign in_acc      = in_i.valid && in_i.ready;
  assign no_expected = (in_i.expected_count == '0);
  assign saturate    = (in_i.lost_count >= in_i.expected_count);

  // The first division runs on the incoming report, the second on the
  // weighted total over the sum of the weights.
  always_comb begin
    div_start = (in_acc && !no_expected && !saturate) || hist_done;
    if (state_q == S_IDLE) begin
      div_rem_init = DEN_W'(in_i.lost_count[COUNT_W-1:1]);
      div_low      = {in_i.lost_count[0], FRAC_W'(0)};
      div_den      = DEN_W'(in_i.expected_count);
    end else begin
      div_rem_init = DEN_W'(hist_total[TOT_W-1:LOSS_W]);
      div_low      = hist_total[LOSS_W-1:0];
      div_den      = DEN_W'(hist_weights);
    end
  end

  wpla_div #(
    .DEN_W (DEN_W),
    .Q_W   (LOSS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (div_rem_init),
    .low_i      (div_low),
    .den_i      (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign hist_push = (state_q == S_PUSH);

  wpla_hist #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .FILL_CNT_W    (FILL_CNT_W),
    .WT_W          (WT_W),
    .TOT_W         (TOT_W)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (hist_push),
    .ratio_i   (ratio_q),
    .done_o    (hist_done),
    .total_o   (hist_total),
    .weights_o (hist_weights),
    .fill_o    (hist_fill)
  );

  assign fill_ext = {FILL_W'(0), hist_fill};

  // Sequencer: ratio, push, walk, average, hand over to the output register.
  always_comb begin
    state_d  = state_q;
    ratio_d  = ratio_q;
    empty_d  = empty_q;
    avg_d    = avg_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          empty_d = no_expected;
          if (no_expected) begin
            ratio_d = '0;
            state_d = S_PUSH;
          end else if (saturate) begin
            ratio_d = wpla_pkg::LOSS_ONE;
            state_d = S_PUSH;
          end else begin
            state_d = S_RATIO;
          end
        end
      end
      S_RATIO: begin
        if (div_done) begin
          ratio_d = div_quot;
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        state_d = S_WALK;
      end
      S_WALK: begin
        if (hist_done) begin
          state_d = S_AVG;
        end
      end
      S_AVG: begin
        if (div_done) begin
          avg_d   = div_quot;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_vld_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_q <= ratio_d;
    empty_q <= empty_d;
    avg_q   <= avg_d;
  end

  // Output register: holds one result until its transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cur_q   <= ratio_q;
      out_avg_q   <= avg_q;
      out_fill_q  <= fill_ext[FILL_W-1:0];
      out_empty_q <= empty_q;
    end
  end

  assign in_i.ready          = (state_q == S_IDLE);
  assign out_o.valid         = out_vld_q;
  assign out_o.current_loss  = out_cur_q;
  assign out_o.weighted_loss = out_avg_q;
  assign out_o.history_fill  = out_fill_q;
  assign out_o.empty_report  = out_empty_q;

`ifndef SYNTHESIS
  // The history never holds more reports than it has slots.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_fill <= FILL_CNT_W'(HISTORY_DEPTH))
    else $error("history fill exceeds depth");

  // The ratio pushed into the history never exceeds 1.0.
  a_ratio_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PUSH) |-> (ratio_q <= wpla_pkg::LOSS_ONE))
    else $error("pushed loss ratio above 1.0");

  // A weighted average is never above the largest entry, i.e. 1.0.
  a_avg_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_AVG && div_done) |-> (div_quot <= wpla_pkg::LOSS_ONE))
    else $error("weighted average above 1.0");

  // The history walk only completes while the sequencer waits for it.
  a_walk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hist_done |-> (state_q == S_WALK))
    else $error("history walk completed out of sequence");
`endif

endmodule : weighted_packet_loss_average

`default_nettype wire
